>>> hdl/spim_pkg.sv
// shared types and constants for the spi master with fifos
package spim_pkg;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic ADDR_CS   = 1'b0;
    localparam logic ADDR_FIFO = 1'b1;

    localparam logic [2:0] OP_NOP     = 3'd0;
    localparam logic [2:0] OP_TICK    = 3'd1;
    localparam logic [2:0] OP_WR_CTRL = 3'd2;
    localparam logic [2:0] OP_WR_FIFO = 3'd3;
    localparam logic [2:0] OP_RD_STAT = 3'd4;
    localparam logic [2:0] OP_RD_FIFO = 3'd5;

    localparam logic [13:0] CTRL_MASK = 14'h3FCF;
    localparam int DONE_BIT = 16;
    localparam int RXD_BIT  = 17;
    localparam int TXD_BIT  = 18;
    localparam int CLR_TX_BIT = 4;
    localparam int CLR_RX_BIT = 5;
    localparam int CPHA_BIT  = 2;
    localparam int CPOL_BIT  = 3;
    localparam int CSPOL_BIT = 6;
    localparam int TA_BIT    = 7;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] wdata;
        logic        miso;
    } op_t;

endpackage

>>> hdl/spim_if.sv
// channel interfaces for input beats, result beats and the divisor write
interface spim_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic        reg_addr;
    logic [15:0] write_data;
    logic        miso;
    modport source (output valid, func, reg_addr, write_data, miso, input ready);
    modport sink (input valid, func, reg_addr, write_data, miso, output ready);
endinterface

interface spim_out_if;
    logic        valid;
    logic        ready;
    logic [18:0] read_data;
    logic        sclk;
    logic        mosi;
    logic [2:0]  cs_lines;
    modport source (output valid, read_data, sclk, mosi, cs_lines, input ready);
    modport sink (input valid, read_data, sclk, mosi, cs_lines, output ready);
endinterface

interface spim_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

>>> hdl/spim_front.sv
// front end: decodes an input beat into a back end operation
module spim_front (
    input  logic [1:0]    func,
    input  logic          reg_addr,
    input  logic [15:0]   write_data,
    input  logic          miso,
    output spim_pkg::op_t op
);
    import spim_pkg::*;

    always_comb
    begin
        op.wdata = write_data;
        op.miso  = miso;
        unique case (func)
            FUNC_TICK:  op.kind = OP_TICK;
            FUNC_WRITE: op.kind = (reg_addr == ADDR_CS) ? OP_WR_CTRL : OP_WR_FIFO;
            FUNC_READ:  op.kind = (reg_addr == ADDR_CS) ? OP_RD_STAT : OP_RD_FIFO;
            default:    op.kind = OP_NOP;
        endcase
    end

endmodule

>>> hdl/spim_queue.sv
// two-entry operation queue between front and back end
module spim_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  spim_pkg::op_t push_op,
    output logic          not_full,
    input  logic          pop,
    output logic          not_empty,
    output spim_pkg::op_t head_op
);
    import spim_pkg::*;

    op_t        entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign not_full  = (count_reg != 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_op   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_op;
    end

endmodule

>>> hdl/spim_back.sv
// back end: register file, fifos, shift engine and result register
module spim_back #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          op_valid,
    input  spim_pkg::op_t op,
    output logic          op_take,
    input  logic [15:0]   div_setting,
    spim_out_if.source    out_ch
);
    import spim_pkg::*;

    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(FIFO_DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(FIFO_DEPTH);

    logic [13:0]   ctrl_reg, ctrl_next;
    logic [7:0]    txq_reg [FIFO_DEPTH];
    logic [7:0]    rxq_reg [FIFO_DEPTH];
    logic [PW-1:0] tx_head_reg, tx_head_next, tx_tail_reg, tx_tail_next;
    logic [PW-1:0] rx_head_reg, rx_head_next, rx_tail_reg, rx_tail_next;
    logic [CW-1:0] tx_count_reg, tx_count_next, rx_count_reg, rx_count_next;
    logic [7:0]    shift_reg, shift_next;
    logic [3:0]    bit_count_reg, bit_count_next;
    logic [15:0]   div_count_reg, div_count_next;
    logic          sclk_level_reg, sclk_level_next;
    logic          latch_reg, latch_next;
    logic          out_valid_reg;
    logic [18:0]   read_data_reg, read_data_next;
    logic          sclk_reg, mosi_reg;
    logic [2:0]    cs_lines_reg, cs_lines_next;
    logic          tx_we, rx_we;
    logic [7:0]    rx_wdata;
    logic [15:0]   div_even;
    logic [16:0]   half;
    logic [16:0]   dc_inc;
    logic          cpha;
    logic          sample;

    assign op_take = op_valid && (!out_valid_reg || out_ch.ready);
    assign div_even = div_setting & 16'hFFFE;
    assign half = (div_even == 16'd0) ? 17'd32768 : {2'b00, div_even[15:1]};
    assign dc_inc = {1'b0, div_count_reg} + 17'd1;
    assign cpha = ctrl_reg[CPHA_BIT];

    always_comb
    begin
        ctrl_next       = ctrl_reg;
        tx_head_next    = tx_head_reg;
        tx_tail_next    = tx_tail_reg;
        tx_count_next   = tx_count_reg;
        rx_head_next    = rx_head_reg;
        rx_tail_next    = rx_tail_reg;
        rx_count_next   = rx_count_reg;
        shift_next      = shift_reg;
        bit_count_next  = bit_count_reg;
        div_count_next  = div_count_reg;
        sclk_level_next = sclk_level_reg;
        latch_next      = latch_reg;
        read_data_next  = 19'd0;
        tx_we           = 1'b0;
        rx_we           = 1'b0;
        sample          = cpha ? op.miso : latch_reg;
        rx_wdata        = {shift_reg[6:0], sample};
        unique case (op.kind)
            OP_TICK:
            begin
                if (ctrl_reg[TA_BIT])
                begin
                    if (bit_count_reg == 4'd0)
                    begin
                        if (tx_count_reg != '0)
                        begin
                            shift_next     = txq_reg[tx_head_reg];
                            tx_head_next   = (tx_head_reg == LAST) ? '0 : tx_head_reg + PW'(1);
                            tx_count_next  = tx_count_reg - CW'(1);
                            bit_count_next = BITS_PER_BYTE;
                            div_count_next = 16'd0;
                            sclk_level_next = 1'b0;
                        end
                    end
                    else if (dc_inc < half)
                    begin
                        div_count_next = dc_inc[15:0];
                    end
                    else
                    begin
                        div_count_next  = 16'd0;
                        sclk_level_next = ~sclk_level_reg;
                        if (!sclk_level_reg)
                        begin
                            if (!cpha)
                                latch_next = op.miso;
                        end
                        else
                        begin
                            shift_next     = rx_wdata;
                            bit_count_next = bit_count_reg - 4'd1;
                            if (bit_count_reg == 4'd1 && rx_count_reg != FULL)
                            begin
                                rx_we         = 1'b1;
                                rx_tail_next  = (rx_tail_reg == LAST) ? '0 : rx_tail_reg + PW'(1);
                                rx_count_next = rx_count_reg + CW'(1);
                            end
                        end
                    end
                end
            end
            OP_WR_CTRL:
            begin
                if (op.wdata[CLR_TX_BIT])
                begin
                    tx_count_next = '0;
                    tx_head_next  = '0;
                    tx_tail_next  = '0;
                end
                if (op.wdata[CLR_RX_BIT])
                begin
                    rx_count_next = '0;
                    rx_head_next  = '0;
                    rx_tail_next  = '0;
                end
                ctrl_next = op.wdata[13:0] & CTRL_MASK;
                if (!op.wdata[TA_BIT])
                begin
                    bit_count_next  = 4'd0;
                    div_count_next  = 16'd0;
                    sclk_level_next = 1'b0;
                    latch_next      = 1'b0;
                end
            end
            OP_WR_FIFO:
            begin
                if (tx_count_reg != FULL)
                begin
                    tx_we         = 1'b1;
                    tx_tail_next  = (tx_tail_reg == LAST) ? '0 : tx_tail_reg + PW'(1);
                    tx_count_next = tx_count_reg + CW'(1);
                end
            end
            OP_RD_STAT:
            begin
                read_data_next = {5'd0, ctrl_reg & CTRL_MASK};
                read_data_next[DONE_BIT] = ctrl_reg[TA_BIT] && tx_count_reg == '0
                                           && bit_count_reg == 4'd0;
                read_data_next[RXD_BIT] = (rx_count_reg != '0);
                read_data_next[TXD_BIT] = (tx_count_reg != FULL);
            end
            OP_RD_FIFO:
            begin
                if (rx_count_reg != '0)
                begin
                    read_data_next = {11'd0, rxq_reg[rx_head_reg]};
                    rx_head_next   = (rx_head_reg == LAST) ? '0 : rx_head_reg + PW'(1);
                    rx_count_next  = rx_count_reg - CW'(1);
                end
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < 3; i++)
        begin
            if (ctrl_next[TA_BIT] && ctrl_next[1:0] == 2'(i))
                cs_lines_next[i] = ctrl_next[CSPOL_BIT];
            else
                cs_lines_next[i] = ~ctrl_next[CSPOL_BIT];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg       <= '0;
            tx_head_reg    <= '0;
            tx_tail_reg    <= '0;
            tx_count_reg   <= '0;
            rx_head_reg    <= '0;
            rx_tail_reg    <= '0;
            rx_count_reg   <= '0;
            shift_reg      <= '0;
            bit_count_reg  <= '0;
            div_count_reg  <= '0;
            sclk_level_reg <= 1'b0;
            latch_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (op_take)
            begin
                ctrl_reg       <= ctrl_next;
                tx_head_reg    <= tx_head_next;
                tx_tail_reg    <= tx_tail_next;
                tx_count_reg   <= tx_count_next;
                rx_head_reg    <= rx_head_next;
                rx_tail_reg    <= rx_tail_next;
                rx_count_reg   <= rx_count_next;
                shift_reg      <= shift_next;
                bit_count_reg  <= bit_count_next;
                div_count_reg  <= div_count_next;
                sclk_level_reg <= sclk_level_next;
                latch_reg      <= latch_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_take)
        begin
            read_data_reg <= read_data_next;
            sclk_reg      <= sclk_level_next ^ ctrl_next[CPOL_BIT];
            mosi_reg      <= (bit_count_next != 4'd0) && shift_next[7];
            cs_lines_reg  <= cs_lines_next;
        end
        if (tx_we)
            txq_reg[tx_tail_reg] <= op.wdata[7:0];
        if (rx_we)
            rxq_reg[rx_tail_reg] <= rx_wdata;
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.read_data = read_data_reg;
    assign out_ch.sclk      = sclk_reg;
    assign out_ch.mosi      = mosi_reg;
    assign out_ch.cs_lines  = cs_lines_reg;

endmodule

>>> hdl/spi_master_fifo_controller_core.sv
// top level of the spi master with transmit and receive fifos
// a beat's result passes through the operation queue and then the back end
// result register before it is valid
// throughput: one beat per cycle while the result side does not stall
// reset: rst_n clears control, fifo fill counts and shift engine at once
module spi_master_fifo_controller_core #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    spim_in_if.sink    in_ch,
    spim_out_if.source out_ch,
    spim_cfg_if.sink   cfg
);
    import spim_pkg::*;

    op_t         front_op;
    op_t         head_op;
    logic        q_not_full;
    logic        q_not_empty;
    logic        op_take;
    logic [15:0] divisor_reg;

    assign in_ch.ready = q_not_full;
    assign cfg.ready   = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            divisor_reg <= 16'd0;
        else if (cfg.valid)
            divisor_reg <= cfg.data;
    end

    spim_front u_front (
        .func       (in_ch.func),
        .reg_addr   (in_ch.reg_addr),
        .write_data (in_ch.write_data),
        .miso       (in_ch.miso),
        .op         (front_op)
    );

    spim_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_ch.valid && q_not_full),
        .push_op   (front_op),
        .not_full  (q_not_full),
        .pop       (op_take),
        .not_empty (q_not_empty),
        .head_op   (head_op)
    );

    spim_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .op_valid    (q_not_empty),
        .op          (head_op),
        .op_take     (op_take),
        .div_setting (divisor_reg),
        .out_ch      (out_ch)
    );

endmodule

>>> sim/spim_checker.sv
// checker: predicts spi master results from observed beats and compares them
`timescale 1ns / 100ps
module spim_checker (
    input  logic       clk,
    input  logic       rst_n,
    spim_in_if         in_ch,
    spim_out_if        out_ch,
    spim_cfg_if        cfg,
    output int         errors,
    output int         pending
);
    import spim_pkg::*;

    typedef struct packed {
        logic [18:0] read_data;
        logic        sclk;
        logic        mosi;
        logic [2:0]  cs_lines;
    } spim_result_t;

    spim_result_t result_q[$];

    logic [15:0] divisor;
    logic [13:0] ctrl;
    logic [7:0]  tx_mem[16];
    logic [7:0]  rx_mem[16];
    int          tx_rd, rx_rd, tx_fill, rx_fill;
    logic [7:0]  shifter;
    int          bits_left;
    int          div_cnt;
    logic        sclk_lvl;
    logic        latch;

    assign pending = result_q.size();

    function automatic int half_ticks();
        int d;
        d = divisor & 16'hFFFE;
        if (d == 0)
            d = 65536;
        return d / 2;
    endfunction

    task automatic halt_shifter();
        bits_left = 0;
        div_cnt = 0;
        sclk_lvl = 1'b0;
        latch = 1'b0;
    endtask

    task automatic tick_engine(input logic miso_in);
        logic cpha;
        cpha = ctrl[CPHA_BIT];
        if (!ctrl[TA_BIT])
            return;
        if (bits_left == 0)
        begin
            if (tx_fill == 0)
                return;
            shifter = tx_mem[tx_rd];
            tx_rd = (tx_rd + 1) % 16;
            tx_fill--;
            bits_left = 8;
            div_cnt = 0;
            sclk_lvl = 1'b0;
            return;
        end
        div_cnt++;
        if (div_cnt < half_ticks())
            return;
        div_cnt = 0;
        sclk_lvl = ~sclk_lvl;
        if (sclk_lvl)
        begin
            if (!cpha)
                latch = miso_in;
            return;
        end
        shifter = {shifter[6:0], cpha ? miso_in : latch};
        bits_left--;
        if (bits_left == 0 && rx_fill < 16)
        begin
            rx_mem[(rx_rd + rx_fill) % 16] = shifter;
            rx_fill++;
        end
    endtask

    task automatic predict_beat(input logic [1:0] fn, input logic adr,
                                input logic [15:0] wd, input logic miso_in);
        spim_result_t r;
        r = '0;
        if (fn == FUNC_TICK)
            tick_engine(miso_in);
        else if (fn == FUNC_WRITE)
        begin
            if (adr == ADDR_CS)
            begin
                if (wd[CLR_TX_BIT])
                begin
                    tx_fill = 0;
                    tx_rd = 0;
                end
                if (wd[CLR_RX_BIT])
                begin
                    rx_fill = 0;
                    rx_rd = 0;
                end
                ctrl = wd[13:0] & CTRL_MASK;
                if (!ctrl[TA_BIT])
                    halt_shifter();
            end
            else if (tx_fill < 16)
            begin
                tx_mem[(tx_rd + tx_fill) % 16] = wd[7:0];
                tx_fill++;
            end
        end
        else if (fn == FUNC_READ)
        begin
            if (adr == ADDR_CS)
            begin
                r.read_data = {5'b0, ctrl};
                r.read_data[DONE_BIT] = ctrl[TA_BIT] && tx_fill == 0 && bits_left == 0;
                r.read_data[RXD_BIT] = rx_fill > 0;
                r.read_data[TXD_BIT] = tx_fill < 16;
            end
            else if (rx_fill > 0)
            begin
                r.read_data = {11'b0, rx_mem[rx_rd]};
                rx_rd = (rx_rd + 1) % 16;
                rx_fill--;
            end
        end
        r.sclk = sclk_lvl ^ ctrl[CPOL_BIT];
        r.mosi = bits_left != 0 ? shifter[7] : 1'b0;
        for (int i = 0; i < 3; i++)
            r.cs_lines[i] = (ctrl[TA_BIT] && ctrl[1:0] == i) ? ctrl[CSPOL_BIT]
                                                            : ~ctrl[CSPOL_BIT];
        result_q.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [18:0] got,
                                   input logic [18:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        spim_result_t e;
        if (!rst_n)
        begin
            errors = 0;
            result_q.delete();
            divisor = '0;
            ctrl = '0;
            tx_rd = 0;
            rx_rd = 0;
            tx_fill = 0;
            rx_fill = 0;
            shifter = '0;
            halt_shifter();
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (result_q.size() == 0)
                begin
                    report_mismatch("unexpected beat", out_ch.read_data, 19'd0);
                end
                else
                begin
                    e = result_q.pop_front();
                    if (out_ch.read_data !== e.read_data)
                        report_mismatch("read_data", out_ch.read_data, e.read_data);
                    if (out_ch.sclk !== e.sclk)
                        report_mismatch("sclk", out_ch.sclk, e.sclk);
                    if (out_ch.mosi !== e.mosi)
                        report_mismatch("mosi", out_ch.mosi, e.mosi);
                    if (out_ch.cs_lines !== e.cs_lines)
                        report_mismatch("cs_lines", out_ch.cs_lines, e.cs_lines);
                end
            end
            if (cfg.valid && cfg.ready)
                divisor = cfg.data;
            if (in_ch.valid && in_ch.ready)
                predict_beat(in_ch.func, in_ch.reg_addr, in_ch.write_data, in_ch.miso);
        end
    end

endmodule

>>> sim/spi_master_fifo_controller_core_test.sv
// testbench top: stimulus for the spi master with fifos and final verdict
`timescale 1ns / 100ps
module spi_master_fifo_controller_core_test;
    import spim_pkg::*;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    longint cycles;

    spim_in_if  in_ch();
    spim_out_if out_ch();
    spim_cfg_if cfg();

    spi_master_fifo_controller_core uut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
    );

    spim_checker checker_i (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 2000000)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // result side stalls
    initial
    begin
        int gap;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if ($urandom_range(0, 4) == 0)
                gap = 0;
            repeat (gap)
            begin
                out_ch.ready = 1'b0;
                @(negedge clk);
            end
            out_ch.ready = 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
        end
    end

    bit burst_mode;

    task automatic send_beat(input logic [1:0] fn, input logic adr,
                             input logic [15:0] wd, input logic miso_in);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 11);
        repeat (gap)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.func = fn;
        in_ch.reg_addr = adr;
        in_ch.write_data = wd;
        in_ch.miso = miso_in;
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic drain_results();
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_divisor(input logic [15:0] d);
        drain_results();
        cfg.valid = 1'b1;
        cfg.data = d;
        do
            @(posedge clk);
        while (!cfg.ready);
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    task automatic random_beat();
        int pick;
        logic [15:0] ctl;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            send_beat(FUNC_TICK, 1'($urandom), 16'($urandom), 1'($urandom));
        else if (pick < 68)
            send_beat(FUNC_WRITE, ADDR_FIFO, 16'($urandom), 1'($urandom));
        else if (pick < 76)
            send_beat(FUNC_READ, ADDR_FIFO, 16'($urandom), 1'($urandom));
        else if (pick < 84)
            send_beat(FUNC_READ, ADDR_CS, 16'($urandom), 1'($urandom));
        else if (pick < 97)
        begin
            ctl = 16'($urandom);
            // mostly keep the transfer running, clears only now and then
            if ($urandom_range(0, 3) != 0)
                ctl[TA_BIT] = 1'b1;
            if ($urandom_range(0, 3) != 0)
                ctl[5:4] = 2'b00;
            send_beat(FUNC_WRITE, ADDR_CS, ctl, 1'($urandom));
        end
        else
            send_beat(2'd3, 1'($urandom), 16'($urandom), 1'($urandom));
    endtask

    initial
    begin
        logic [15:0] divs[6];
        divs = '{16'd2, 16'd1, 16'd4, 16'd3, 16'd7, 16'd6};
        burst_mode = 1'b0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.func = FUNC_TICK;
        in_ch.reg_addr = ADDR_CS;
        in_ch.write_data = '0;
        in_ch.miso = 1'b0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: idle reads, status, selects, polarity, clears, func 3
        send_beat(FUNC_READ, ADDR_FIFO, 16'hFFFF, 1'b1);
        send_beat(FUNC_READ, ADDR_CS, 16'h0000, 1'b0);
        send_beat(FUNC_TICK, ADDR_CS, 16'h0000, 1'b1);
        send_beat(FUNC_WRITE, ADDR_CS, 16'hFFCB, 1'b0);
        send_beat(FUNC_READ, ADDR_CS, 16'h0000, 1'b0);
        send_beat(FUNC_WRITE, ADDR_CS, 16'h00C3, 1'b1);
        send_beat(2'd3, ADDR_FIFO, 16'hFFFF, 1'b1);
        for (int i = 0; i < 17; i++)
            send_beat(FUNC_WRITE, ADDR_FIFO, 16'hFF00 | 16'(i * 15), 1'b0);
        send_beat(FUNC_READ, ADDR_CS, 16'h0000, 1'b0);
        send_beat(FUNC_WRITE, ADDR_CS, 16'h0030, 1'b0);
        send_beat(FUNC_READ, ADDR_CS, 16'h0000, 1'b0);
        drain_results();

        write_divisor(16'd2);
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph > 0)
                write_divisor(divs[ph]);
            if (ph == 1)
            begin
                // divisor one means a very long clock: only start a byte
                send_beat(FUNC_WRITE, ADDR_CS, 16'h0080, 1'b0);
                send_beat(FUNC_WRITE, ADDR_FIFO, 16'h00A5, 1'b0);
                for (int k = 0; k < 20; k++)
                    send_beat(FUNC_TICK, ADDR_CS, 16'h0, 1'($urandom));
                send_beat(FUNC_READ, ADDR_CS, 16'h0, 1'b0);
                send_beat(FUNC_WRITE, ADDR_CS, 16'h0000, 1'b0);
                continue;
            end
            // overfill the transmit fifo to hit its drop case, then fill the receive fifo
            if (ph == 0)
            begin
                send_beat(FUNC_WRITE, ADDR_CS, 16'h00A4, 1'b0);
                for (int k = 0; k < 18; k++)
                    send_beat(FUNC_WRITE, ADDR_FIFO, 16'($urandom), 1'b0);
                burst_mode = 1'b1;
                for (int k = 0; k < 400; k++)
                    send_beat(FUNC_TICK, ADDR_CS, 16'h0, 1'($urandom));
                burst_mode = 1'b0;
                for (int k = 0; k < 17; k++)
                    send_beat(FUNC_READ, ADDR_FIFO, 16'h0, 1'b0);
            end
            if (ph == 3)
                drain_results();
            burst_mode = ph == 4;
            for (int k = 0; k < 80; k++)
                random_beat();
            burst_mode = 1'b0;
        end
        write_divisor(16'hFFFF);
        send_beat(FUNC_WRITE, ADDR_CS, 16'h00C9, 1'b0);
        send_beat(FUNC_WRITE, ADDR_FIFO, 16'h005A, 1'b0);
        send_beat(FUNC_TICK, ADDR_CS, 16'h0, 1'b1);
        send_beat(FUNC_READ, ADDR_CS, 16'h0, 1'b0);
        write_divisor(16'h0000);

        drain_results();
        repeat (10) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
